// ===== hw/rtl/markup_tag_balance_checker_defines.svh =====
// Assertion macros for the markup tag balance checker.
`ifndef MARKUP_TAG_BALANCE_CHECKER_DEFINES_SVH
`define MARKUP_TAG_BALANCE_CHECKER_DEFINES_SVH

`ifndef ASSERT_OFF

// ante holds at an edge, so cons holds at the same edge
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// ante holds at an edge, so cons holds at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

// cond never holds out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: condition seen");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/mtbc_pkg.sv =====
// Shared types, constants and helpers of the markup tag balance checker.
`timescale 1ns / 1ps
package mtbc_pkg;

    localparam int STACK_DEPTH_DFLT = 128;
    localparam int NAME_LENGTH_DFLT = 64;

    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_I     = 8'h69;  // 'i'
    localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
    localparam logic [7:0] CH_G     = 8'h67;  // 'g'

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_MISMATCH     = 3'd1,
        ST_UNCLOSED     = 3'd2,
        ST_OVERFLOW     = 3'd3,
        ST_TOO_LONG     = 3'd4,
        ST_UNTERMINATED = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic       well_formed;
        logic [2:0] status;
    } t_out_item;

    // Byte of the self-closing name at a given position
    function automatic logic [7:0] self_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_I;
            2'd1:    ch = CH_M;
            2'd2:    ch = CH_G;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/mtbc_name_stack.sv =====
// Name stack store: name bytes per slot and one length per slot, registered reads.
`timescale 1ns / 1ps
module mtbc_name_stack #(
    parameter int STACK_DEPTH = mtbc_pkg::STACK_DEPTH_DFLT,
    parameter int NAME_LENGTH = mtbc_pkg::NAME_LENGTH_DFLT
) (
    input  logic                           i_clk,
    input  logic                           i_name_we,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_name_wslot,
    input  logic [$clog2(NAME_LENGTH)-1:0] i_name_wpos,
    input  logic [7:0]                     i_name_wbyte,
    input  logic                           i_len_we,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_len_wslot,
    input  logic [$clog2(NAME_LENGTH)-1:0] i_len_wdata,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_rd_slot,
    input  logic [$clog2(NAME_LENGTH)-1:0] i_rd_pos,
    output logic [7:0]                     o_rd_byte,
    output logic [$clog2(NAME_LENGTH)-1:0] o_rd_len
);
    import mtbc_pkg::*;

    localparam int PW         = $clog2(NAME_LENGTH);
    localparam int NAME_WORDS = STACK_DEPTH * NAME_LENGTH;
    localparam int AW         = $clog2(NAME_WORDS);

    logic [7:0]    r_name_mem [NAME_WORDS];
    logic [PW-1:0] r_len_mem  [STACK_DEPTH];
    logic [AW-1:0] name_waddr;
    logic [AW-1:0] name_raddr;
    logic [7:0]    r_rd_byte;
    logic [PW-1:0] r_rd_len;

    // Slot s holds its name at s * NAME_LENGTH + position
    assign name_waddr = AW'(i_name_wslot) * AW'(NAME_LENGTH) + AW'(i_name_wpos);
    assign name_raddr = AW'(i_rd_slot) * AW'(NAME_LENGTH) + AW'(i_rd_pos);

    always_ff @(posedge i_clk) begin
        if (i_name_we) begin
            r_name_mem[name_waddr] <= i_name_wbyte;
        end
        r_rd_byte <= r_name_mem[name_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_len_we) begin
            r_len_mem[i_len_wslot] <= i_len_wdata;
        end
        r_rd_len <= r_len_mem[i_rd_slot];
    end

    assign o_rd_byte = r_rd_byte;
    assign o_rd_len  = r_rd_len;

endmodule

// ===== hw/rtl/markup_tag_balance_checker.sv =====
// Top level of the markup tag balance checker: tag parser around the name stack store.
`timescale 1ns / 1ps
`include "markup_tag_balance_checker_defines.svh"
// Checks that the tags of a markup text, fed one byte per transaction, nest and
// close properly. Bytes are taken back to back, with no restriction on the byte
// pattern: the name bytes on top of the stack and the top length are read ahead
// from the registered stack store, using the position the next byte will need.
// One result transaction follows each byte marked last, in the cycle after it
// is taken; the result register lets the next text begin while that result is
// still held. The input stalls only while a result waits and the output side
// stalls too. The stack store needs no clearing after reset: only entries
// written in the current text are ever compared.
module markup_tag_balance_checker #(
    parameter int STACK_DEPTH = mtbc_pkg::STACK_DEPTH_DFLT,
    parameter int NAME_LENGTH = mtbc_pkg::NAME_LENGTH_DFLT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mtbc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mtbc_pkg::t_out_item o_out_data
);
    import mtbc_pkg::*;

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int PW = $clog2(NAME_LENGTH);

    typedef enum logic [1:0] {
        MODE_OUTSIDE,
        MODE_AFTER_LT,
        MODE_OPEN,
        MODE_CLOSE
    } t_mode;

    t_mode         r_mode,  n_mode;
    logic [PW-1:0] r_pos,   n_pos;
    logic [CW-1:0] r_count, n_count;
    logic          r_match, n_match;
    logic [1:0]    r_prog,  n_prog;
    t_status       r_err,   n_err;
    logic          r_out_valid;
    t_out_item     r_out_data;

    logic          in_acc;
    logic [7:0]    in_byte;
    logic          pos_full;
    logic          stack_full;
    logic          stack_empty;
    logic          is_img;
    logic          name_we;
    logic          len_we;
    logic [CW-1:0] rd_top;
    logic [7:0]    rd_byte;
    logic [PW-1:0] rd_len;
    t_status       verdict;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign in_byte     = i_in_data.text_byte;
    assign pos_full    = r_pos >= PW'(NAME_LENGTH - 1);
    assign stack_full  = r_count >= CW'(STACK_DEPTH);
    assign stack_empty = r_count == '0;
    assign is_img      = (r_prog == 2'd3) && (r_pos == PW'(3));

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_count = r_count;
        n_match = r_match;
        n_prog  = r_prog;
        n_err   = r_err;
        name_we = 1'b0;
        len_we  = 1'b0;
        verdict = ST_OK;

        if (in_acc && r_err == ST_OK) begin
            case (r_mode)
                MODE_OUTSIDE: begin
                    if (in_byte == CH_LT) begin
                        n_mode  = MODE_AFTER_LT;
                        n_pos   = '0;
                        n_prog  = '0;
                        n_match = 1'b1;
                    end
                end
                MODE_AFTER_LT, MODE_OPEN: begin
                    if (r_mode == MODE_AFTER_LT && in_byte == CH_SLASH) begin
                        n_mode = MODE_CLOSE;
                    end else if (in_byte == CH_GT) begin
                        n_mode = MODE_OUTSIDE;
                        if (!is_img) begin
                            if (stack_full) begin
                                n_err = ST_OVERFLOW;
                            end else begin
                                len_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                    end else begin
                        n_mode = MODE_OPEN;
                        if (pos_full) begin
                            n_err = ST_TOO_LONG;
                        end else begin
                            name_we = !stack_full;
                            if (r_pos < PW'(3) && r_prog == r_pos[1:0] &&
                                in_byte == self_char(r_pos[1:0])) begin
                                n_prog = r_prog + 2'd1;
                            end
                            n_pos = r_pos + PW'(1);
                        end
                    end
                end
                MODE_CLOSE: begin
                    if (in_byte == CH_GT) begin
                        n_mode = MODE_OUTSIDE;
                        if (stack_empty || !r_match || r_pos != rd_len) begin
                            n_err = ST_MISMATCH;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end else if (pos_full) begin
                        n_err = ST_TOO_LONG;
                    end else begin
                        if (stack_empty || r_pos >= rd_len || rd_byte != in_byte) begin
                            n_match = 1'b0;
                        end
                        n_pos = r_pos + PW'(1);
                    end
                end
                default: begin
                    n_mode = MODE_OUTSIDE;
                end
            endcase
        end

        if (n_err != ST_OK) begin
            verdict = n_err;
        end else if (n_mode != MODE_OUTSIDE) begin
            verdict = ST_UNTERMINATED;
        end else if (n_count != '0) begin
            verdict = ST_UNCLOSED;
        end else begin
            verdict = ST_OK;
        end

        // Drop all parse state after the last byte so the next text starts clean
        if (in_acc && i_in_data.last_byte) begin
            n_mode  = MODE_OUTSIDE;
            n_pos   = '0;
            n_count = '0;
            n_match = 1'b1;
            n_prog  = '0;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OUTSIDE;
            r_pos   <= '0;
            r_count <= '0;
            r_match <= 1'b1;
            r_prog  <= '0;
            r_err   <= ST_OK;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_match <= n_match;
            r_prog  <= n_prog;
            r_err   <= n_err;
        end
    end

    // Result register: load on the last byte, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_in_data.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.last_byte) begin
            r_out_data.well_formed <= verdict == ST_OK;
            r_out_data.status      <= verdict;
        end
    end

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Prefetch the top entry at the position the next byte will use
    assign rd_top = n_count - CW'(1);

    mtbc_name_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .NAME_LENGTH (NAME_LENGTH)
    ) u_name_stack (
        .i_clk        (i_clk),
        .i_name_we    (name_we),
        .i_name_wslot (r_count[SW-1:0]),
        .i_name_wpos  (r_pos),
        .i_name_wbyte (in_byte),
        .i_len_we     (len_we),
        .i_len_wslot  (r_count[SW-1:0]),
        .i_len_wdata  (r_pos),
        .i_rd_slot    (rd_top[SW-1:0]),
        .i_rd_pos     (n_pos),
        .o_rd_byte    (rd_byte),
        .o_rd_len     (rd_len)
    );

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(STACK_DEPTH))
    `ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, in_acc && i_in_data.last_byte, o_out_valid)
    `ASSERT_IMPLY(a_verdict_agrees, i_clk, i_rst_n, o_out_valid,
                  o_out_data.well_formed == (o_out_data.status == ST_OK))
    `ASSERT_NEXT(a_error_held, i_clk, i_rst_n,
                 r_err != ST_OK && !(in_acc && i_in_data.last_byte), r_err == $past(r_err))

endmodule
